@@ design/hds_pkg.sv @@
// Shared types and constants for the heat diffusion stencil core.
// No dependencies; imported by hds_arith and heat_diffusion_stencil_core.
package hds_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_COEF_V = 2'd0;
  localparam logic [1:0] REG_COEF_H = 2'd1;
  localparam logic [1:0] REG_COLS   = 2'd2;
  localparam logic [1:0] REG_ROWS   = 2'd3;

  localparam logic [15:0] COEF_RESET = 16'd6554;
  localparam logic [9:0]  COLS_RESET = 10'd512;
  localparam logic [15:0] ROWS_RESET = 16'd400;

  // Result queue: one entry per item that has results
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int RESV_W     = 4;

  // Per-item control carried beside the arithmetic pipeline
  typedef struct packed {
    logic emit;      // item has results (not in the first row)
    logic pass;      // border point: value passes through
    logic last_row;  // item also emits its own pass-through value
    logic last_col;
  } hds_ctl_t;

  typedef struct packed {
    logic signed [31:0] value;  // finished point of the row above
    logic signed [31:0] temp;   // pass-through value of the last row
    logic               last_row;
    logic               last_col;
  } hds_entry_t;

endpackage

@@ design/heat_diffusion_stencil_core.sv @@
// Top level: one explicit heat diffusion step over a raster-order grid.
// Depends on hds_pkg and hds_arith.
//
//  channel   | direction | handshake              | payload
//  s_axis    | in        | tvalid/tready          | tdata[31:0] temperature
//  m_axis    | out       | tvalid/tready          | tdata[31:0] new_temperature,
//            |           |                        | tlast run_last, tuser grid_last
//  cfg       | in        | cfg_write, no wait     | cfg_index, cfg_data[15:0]
//
// One item per cycle while the result queue has room; items of the last row give
// two results each, so there the single result port limits the input rate.
// Line buffer read at accept, one stage for windows and buffer writes, three
// arithmetic stages, after which a result is written to the 8-entry result queue.
// Reset clears counters, queue pointers and valid flags, loads the configuration
// defaults and holds ready low; line buffers and data registers hold until written.
// Ready drops while queued plus in-flight items fill the queue.
module heat_diffusion_stencil_core import hds_pkg::*; #(
  parameter int MAX_COLS = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] temperature
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] new_temperature
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // [0] grid_last
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW   = $clog2(MAX_COLS);
  localparam int CMPW = (CW + 1 > 10) ? CW + 1 : 10;

  // configuration
  logic [15:0] coef_v;
  logic [15:0] coef_h;
  logic [9:0]  num_cols;
  logic [15:0] num_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_v   <= COEF_RESET;
      coef_h   <= COEF_RESET;
      num_cols <= COLS_RESET;
      num_rows <= ROWS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COEF_V: coef_v   <= cfg_data;
        REG_COEF_H: coef_h   <= cfg_data;
        REG_COLS:   num_cols <= cfg_data[9:0];
        REG_ROWS:   num_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  // counters and row/column end detection
  logic [CW-1:0]   col_count;
  logic [15:0]     row_count;
  logic [CMPW-1:0] cols_eff;
  logic [15:0]     rows_eff;
  logic            last_col;
  logic            last_row;
  logic            accept;
  logic [CW-1:0]   rd_next_addr;

  always_comb begin
    if (CMPW'(num_cols) < CMPW'(3)) begin
      cols_eff = CMPW'(3);
    end else if (CMPW'(num_cols) > CMPW'(MAX_COLS)) begin
      cols_eff = CMPW'(MAX_COLS);
    end else begin
      cols_eff = CMPW'(num_cols);
    end
  end

  assign rows_eff = (num_rows < 16'd3) ? 16'd3 : num_rows;
  assign last_col = (CMPW'(col_count) + CMPW'(1)) >= cols_eff;
  assign last_row = ({1'b0, row_count} + 17'd1) >= {1'b0, rows_eff};
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign rd_next_addr = (CMPW'(col_count) == CMPW'(MAX_COLS - 1)) ? '0 :
                        col_count + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? 16'd0 : row_count + 16'd1;
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  // line buffers
  logic signed [31:0] above_mem  [MAX_COLS];
  logic signed [31:0] center_mem [MAX_COLS];
  logic signed [31:0] above_rd;
  logic signed [31:0] center_rd;

  // window stage registers
  logic               s1_valid;
  logic signed [31:0] s1_t;
  logic [CW-1:0]      s1_col;
  logic               s1_emit;
  logic               s1_row1;
  logic               s1_col0;
  logic               s1_last_col;
  logic               s1_last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_t        <= s_axis_tdata;
      s1_col      <= col_count;
      s1_emit     <= (row_count != 16'd0);
      s1_row1     <= (row_count == 16'd1);
      s1_col0     <= (col_count == '0);
      s1_last_col <= last_col;
      s1_last_row <= last_row;
      above_rd    <= above_mem[col_count];
      center_rd   <= center_mem[rd_next_addr];
    end
  end

  // center row window; the first column comes from a copy of its buffer entry
  logic signed [31:0] win1;
  logic signed [31:0] win2;
  logic signed [31:0] col0_val;
  logic signed [31:0] win1_next;
  hds_ctl_t           s1_ctl;

  assign win1_next = s1_col0 ? col0_val : win2;

  always_comb begin
    s1_ctl.emit     = s1_emit;
    s1_ctl.pass     = s1_row1 || s1_col0 || s1_last_col;
    s1_ctl.last_row = s1_last_row;
    s1_ctl.last_col = s1_last_col;
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      win1                   <= win1_next;
      win2                   <= center_rd;
      above_mem[s1_col]      <= win1_next;
      center_mem[s1_col]     <= s1_t;
      if (s1_col0) begin
        col0_val <= s1_t;
      end
    end
  end

  logic               ar_valid;
  hds_ctl_t           ar_ctl;
  logic signed [31:0] ar_value;
  logic signed [31:0] ar_temp;

  hds_arith u_arith (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ctl    (s1_ctl),
    .u         (win1_next),
    .up        (above_rd),
    .down      (s1_t),
    .west      (win1),
    .east      (center_rd),
    .coef_v    (coef_v),
    .coef_h    (coef_h),
    .out_valid (ar_valid),
    .out_ctl   (ar_ctl),
    .out_value (ar_value),
    .out_temp  (ar_temp)
  );

  // result queue, one entry per item with results
  hds_entry_t         fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [RESV_W-1:0]  fill;
  logic [RESV_W-1:0]  resv;
  logic               half;
  logic               push;
  logic               drop;
  logic               out_acc;
  logic               pop;
  hds_entry_t         head;
  hds_entry_t         new_entry;

  assign push = ar_valid && ar_ctl.emit;
  assign drop = ar_valid && !ar_ctl.emit;
  assign head = fifo[rd_ptr];

  always_comb begin
    new_entry.value    = ar_value;
    new_entry.temp     = ar_temp;
    new_entry.last_row = ar_ctl.last_row;
    new_entry.last_col = ar_ctl.last_col;
  end

  assign m_axis_tvalid = (fill != '0);
  assign m_axis_tdata  = half ? head.temp : head.value;
  assign m_axis_tlast  = half || !head.last_row;
  assign m_axis_tuser  = half && head.last_col;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign pop           = out_acc && (half || !head.last_row);

  // reserve a slot at accept, release it at pop or when an item has no result
  assign s_axis_tready = !rst && (resv < RESV_W'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
      resv   <= '0;
      half   <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fill <= fill + RESV_W'(push) - RESV_W'(pop);
      resv <= resv + RESV_W'(accept) - RESV_W'(pop) - RESV_W'(drop);
      if (out_acc) begin
        half <= half ? 1'b0 : head.last_row;
      end
    end
  end

endmodule

@@ design/hds_arith.sv @@
// Three-stage stencil arithmetic: differences, Q0.16 weighting, sum and saturation.
// Depends on hds_pkg for the control struct.
module hds_arith import hds_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  hds_ctl_t           in_ctl,
  input  logic signed [31:0] u,
  input  logic signed [31:0] up,
  input  logic signed [31:0] down,
  input  logic signed [31:0] west,
  input  logic signed [31:0] east,
  input  logic        [15:0] coef_v,
  input  logic        [15:0] coef_h,
  output logic               out_valid,
  output hds_ctl_t           out_ctl,
  output logic signed [31:0] out_value,
  output logic signed [31:0] out_temp
);

  // stage a: exact differences
  logic               a_valid;
  hds_ctl_t           a_ctl;
  logic signed [31:0] a_u;
  logic signed [31:0] a_t;
  logic signed [34:0] a_dv;
  logic signed [34:0] a_dh;

  // stage b: weighted terms
  logic               b_valid;
  hds_ctl_t           b_ctl;
  logic signed [31:0] b_u;
  logic signed [31:0] b_t;
  logic signed [51:0] b_pv;
  logic signed [51:0] b_ph;

  logic signed [34:0] dv;
  logic signed [34:0] dh;
  logic signed [34:0] u2;
  logic signed [51:0] pv;
  logic signed [51:0] ph;
  logic signed [37:0] sum;
  logic signed [31:0] sat;

  assign u2 = {{2{u[31]}}, u, 1'b0};
  assign dv = {{3{up[31]}}, up} + {{3{down[31]}}, down} - u2;
  assign dh = {{3{west[31]}}, west} + {{3{east[31]}}, east} - u2;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_ctl <= in_ctl;
    a_u   <= u;
    a_t   <= down;
    a_dv  <= dv;
    a_dh  <= dh;
  end

  assign pv = $signed({1'b0, coef_v}) * a_dv;
  assign ph = $signed({1'b0, coef_h}) * a_dh;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_ctl <= a_ctl;
    b_u   <= a_u;
    b_t   <= a_t;
    b_pv  <= pv;
    b_ph  <= ph;
  end

  // drop 16 fraction bits with floor, then clamp to 32 bits
  assign sum = {{6{b_u[31]}}, b_u} + {{2{b_pv[51]}}, b_pv[51:16]}
             + {{2{b_ph[51]}}, b_ph[51:16]};

  always_comb begin
    if (sum[37:31] == 7'h00 || sum[37:31] == 7'h7f) begin
      sat = sum[31:0];
    end else if (sum[37]) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= b_valid;
    end
    out_ctl   <= b_ctl;
    out_value <= b_ctl.pass ? b_u : sat;
    out_temp  <= b_t;
  end

endmodule
